// ----- rtl/memory_lcd_framebuffer_refresh_macros.svh -----
// assertion helpers used by the framebuffer refresh module
`ifndef MEMORY_LCD_FRAMEBUFFER_REFRESH_MACROS_SVH
`define MEMORY_LCD_FRAMEBUFFER_REFRESH_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ----- rtl/mlfr_pkg.sv -----
package mlfr_pkg;

   localparam int LINES          = 128;
   localparam int BYTES_PER_LINE = 16;

   localparam int STORE_BYTES = LINES * BYTES_PER_LINE;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LINE_SLOT   = BYTES_PER_LINE + 2;
   localparam int REFRESH_LEN = 2 + LINES * LINE_SLOT;
   localparam int POS_W       = $clog2(REFRESH_LEN);
   localparam int LINE_W      = $clog2(LINES);
   localparam int OFF_W       = $clog2(LINE_SLOT);
   localparam int X_LIMIT     = 8 * BYTES_PER_LINE;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_CMD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_CMD = 2'd2;

   localparam logic [7:0] BYTE_WHITE = 8'hFF;
   localparam logic [7:0] BYTE_BLACK = 8'h00;
   localparam logic [7:0] BYTE_DUMMY = 8'h00;
   localparam logic [7:0] WRITE_CMD_RESET = 8'h01;
   localparam logic [7:0] CLEAR_CMD_RESET = 8'h04;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_REFRESH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_IDLE    = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_REFRESH = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_FILL = 2'd1,
      ST_DRAW = 2'd2,
      ST_TICK = 2'd3
   } state_type;

endpackage

// ----- rtl/memory_lcd_framebuffer_refresh.sv -----
// tick: response registered when the output is free; no request taken until it is loaded
// draw: read-modify-write of one store byte through the registered store read
// clear: fill of the whole store at one byte per cycle, no requests taken meanwhile
// reset: synchronous; starts the same white fill, control registers to their defaults
`include "memory_lcd_framebuffer_refresh_macros.svh"

module memory_lcd_framebuffer_refresh (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic [7:0]                     req_pixel_x,
   input  logic [7:0]                     req_pixel_y,
   input  logic                           req_pixel_white,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_spi_byte,
   output logic                           rsp_end_of_transfer,
   input  logic                           csr_write_en,
   input  logic [mlfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import mlfr_pkg::*;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [ADDR_W-1:0]  fill_ff, fill_in;
   logic [7:0]         fill_val_ff, fill_val_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [2:0]         bit_ff, bit_in;
   logic               set_ff, set_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               invert_ff;
   logic [7:0]         write_cmd_ff;
   logic [7:0]         clear_cmd_ff;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [7:0]         ram_rd_data;

   logic [ADDR_W-1:0]  draw_addr;
   logic [ADDR_W-1:0]  tick_addr;
   logic               draw_in_range;
   logic [7:0]         line_byte;
   logic [7:0]         draw_mask;
   logic               rsp_load;
   logic               tick_last;
   logic [7:0]         tick_byte;
   logic               clear_taken;

   mlfr_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign draw_addr     = ADDR_W'(int'(req_pixel_x) / 8 + int'(req_pixel_y) * BYTES_PER_LINE);
   assign draw_in_range = (int'(req_pixel_x) < X_LIMIT) && (int'(req_pixel_y) < LINES);
   // store byte for the current slot; meaningless when the slot holds the line address
   assign tick_addr     = ADDR_W'(int'(line_ff) * BYTES_PER_LINE + int'(off_ff) - 1);
   assign line_byte     = 8'(int'(line_ff) + 1);
   assign draw_mask     = 8'(1) << bit_ff;
   assign clear_taken   = req_valid && req_ready && (cmd_type'(req_cmd) == CMD_CLEAR)
                          && (kind_ff == KIND_IDLE);

   // byte and last flag of the pending tick
   always_comb begin
      tick_byte = BYTE_DUMMY;
      tick_last = 1'b0;
      if (kind_ff == KIND_CLEAR) begin
         tick_byte = (pos_ff == '0) ? clear_cmd_ff : BYTE_DUMMY;
         tick_last = (pos_ff != '0);
      end else if (pos_ff == '0) begin
         tick_byte = write_cmd_ff;
      end else if (pos_ff >= POS_W'(REFRESH_LEN - 1)) begin
         tick_last = 1'b1;
      end else if (off_ff == '0) begin
         tick_byte = line_byte;
      end else if (int'(off_ff) <= BYTES_PER_LINE) begin
         tick_byte = ram_rd_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      line_in     = line_ff;
      off_in      = off_ff;
      fill_in     = fill_ff;
      fill_val_in = fill_val_ff;
      addr_in     = addr_ff;
      bit_in      = bit_ff;
      set_in      = set_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tick_addr;
      req_ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (cmd_type'(req_cmd))
                  CMD_TICK: begin
                     if (kind_ff != KIND_IDLE) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_TICK;
                     end
                  end
                  CMD_DRAW: begin
                     if (kind_ff == KIND_IDLE && draw_in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = draw_addr;
                        addr_in     = draw_addr;
                        bit_in      = req_pixel_x[2:0];
                        set_in      = req_pixel_white ^ invert_ff;
                        state_in    = ST_DRAW;
                     end
                  end
                  CMD_CLEAR: begin
                     if (kind_ff == KIND_IDLE) begin
                        kind_in     = KIND_CLEAR;
                        pos_in      = '0;
                        fill_in     = '0;
                        fill_val_in = invert_ff ? BYTE_BLACK : BYTE_WHITE;
                        state_in    = ST_FILL;
                     end
                  end
                  CMD_REFRESH: begin
                     if (kind_ff == KIND_IDLE) begin
                        kind_in = KIND_REFRESH;
                        pos_in  = '0;
                        line_in = '0;
                        off_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAW: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = set_ff ? (ram_rd_data | draw_mask) : (ram_rd_data & ~draw_mask);
            state_in    = ST_IDLE;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff;
            ram_wr_data = fill_val_ff;
            fill_in     = fill_ff + 1'b1;
            if (fill_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            // wait here until the response register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load    = 1'b1;
               rsp_byte_in = tick_byte;
               rsp_end_in  = tick_last;
               state_in    = ST_IDLE;
               if (tick_last) begin
                  kind_in = KIND_IDLE;
                  pos_in  = '0;
                  line_in = '0;
                  off_in  = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  // slot counters track pos - 1 once past the command byte
                  if (pos_ff != '0) begin
                     if (off_ff == OFF_W'(LINE_SLOT - 1)) begin
                        off_in  = '0;
                        line_in = line_ff + 1'b1;
                     end else begin
                        off_in = off_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         kind_ff      <= KIND_IDLE;
         pos_ff       <= '0;
         line_ff      <= '0;
         off_ff       <= '0;
         fill_ff      <= '0;
         fill_val_ff  <= BYTE_WHITE;
         rsp_valid_ff <= 1'b0;
         invert_ff    <= 1'b0;
         write_cmd_ff <= WRITE_CMD_RESET;
         clear_cmd_ff <= CLEAR_CMD_RESET;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         off_ff       <= off_in;
         fill_ff      <= fill_in;
         fill_val_ff  <= fill_val_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_INVERT:    invert_ff    <= csr_wdata[0];
               CSR_WRITE_CMD: write_cmd_ff <= csr_wdata;
               CSR_CLEAR_CMD: clear_cmd_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      bit_ff      <= bit_in;
      set_ff      <= set_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_spi_byte        = rsp_byte_ff;
   assign rsp_end_of_transfer = rsp_end_ff;

   `ASSERT_NEXT(a_eot_goes_idle, clock, reset, rsp_load && rsp_end_in, kind_ff == KIND_IDLE)
   `ASSERT_IMPL(a_pos_in_range, clock, reset, kind_ff == KIND_REFRESH, pos_ff <= POS_W'(REFRESH_LEN - 1))
   `ASSERT_IMPL(a_off_in_range, clock, reset, kind_ff == KIND_REFRESH, off_ff <= OFF_W'(LINE_SLOT - 1))
   `ASSERT_NEXT(a_clear_fills, clock, reset, clear_taken, (state_ff == ST_FILL) && (kind_ff == KIND_CLEAR))

endmodule

// ----- rtl/mlfr_ram.sv -----
module mlfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
